// ===== rtl/ita_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; the other RTL modules and the bench refer to this package by scoped names.
package ita_pkg;

  localparam int MAX_WIDTH     = 64;
  localparam int MAX_PRECISION = 32;
  localparam int DIGIT_SLOTS   = 24;

  localparam int VALUE_W = 64;
  localparam int WID_W   = 7;
  localparam int PREC_W  = 6;
  localparam int IDX_W   = $clog2(DIGIT_SLOTS);
  localparam int ND_W    = $clog2(DIGIT_SLOTS + 1);
  localparam int STEP_W  = $clog2(VALUE_W);

  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = (VALUE_W + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_W + 2) / 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int SEG_COUNT   = 8;

  localparam logic [2:0] REQ_SDEC = 3'd0;
  localparam logic [2:0] REQ_UDEC = 3'd1;
  localparam logic [2:0] REQ_LHEX = 3'd2;
  localparam logic [2:0] REQ_UHEX = 3'd3;
  localparam logic [2:0] REQ_OCT  = 3'd4;
  localparam logic [2:0] REQ_PTR  = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  typedef enum logic [1:0] {
    RDX_DEC,
    RDX_HEX,
    RDX_OCT
  } radix_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DABBLE,
    F_SCAN,
    F_PLAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    SEG_LPAD,
    SEG_SIGN,
    SEG_PFX0,
    SEG_PFXX,
    SEG_ZPAD,
    SEG_PREC,
    SEG_DIG,
    SEG_TPAD,
    SEG_IDLE
  } seg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [2:0]         req_type;
    logic [WID_W-1:0]   min_chars;
    logic [PREC_W-1:0]  min_digits;
    logic               alt_prefix;
    logic               left_justify;
    logic               zero_pad;
  } ita_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } ita_out_t;

  typedef struct packed {
    logic [DIGIT_SLOTS-1:0][3:0] digits;
    logic [ND_W-1:0]             nd;
    logic                        neg;
    logic [1:0]                  plen;
    logic                        upper;
    logic [PREC_W-1:0]           pz;
    logic [WID_W-1:0]            pad;
    logic                        left;
    logic                        zfill;
  } ita_rec_t;

  function automatic logic [7:0] glyph(input logic [3:0] d, input logic upper);
    logic [7:0] dx;
    dx = {4'h0, d};
    if (d < 4'd10) begin
      return dx + 8'h30;
    end else if (upper) begin
      return dx + 8'h37;
    end else begin
      return dx + 8'h57;
    end
  endfunction

endpackage

// ===== rtl/ita_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Used for the input, the internal record queue and the character output.
interface ita_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ita_front.sv =====
// Front end: accepts a request, classifies it, extracts the digits and plans the layout.
// Depends on ita_pkg and ita_stream_if.
module ita_front (
  input  logic          clk,
  input  logic          rst_n,
  ita_stream_if.sink    in_item,
  ita_stream_if.source  rec_out
);

  localparam int VALUE_W = ita_pkg::VALUE_W;
  localparam int WID_W   = ita_pkg::WID_W;
  localparam int PREC_W  = ita_pkg::PREC_W;
  localparam int IDX_W   = ita_pkg::IDX_W;
  localparam int ND_W    = ita_pkg::ND_W;
  localparam int STEP_W  = ita_pkg::STEP_W;
  localparam int SLOTS   = ita_pkg::DIGIT_SLOTS;
  localparam int EXT_W   = 4 * SLOTS;

  ita_pkg::front_state_t state_r, state_nxt;
  ita_pkg::radix_t       radix_r, radix_nxt;

  logic [VALUE_W-1:0]      bin_r, bin_nxt;
  logic [SLOTS-1:0][3:0]   dig_r, dig_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [ND_W-1:0]         nd_r, nd_nxt;
  logic                    neg_r, neg_nxt;
  logic                    nz_r, nz_nxt;
  logic                    ptr_r, ptr_nxt;
  logic                    upper_r, upper_nxt;
  logic                    alt_r, alt_nxt;
  logic                    left_r, left_nxt;
  logic                    zfill_r, zfill_nxt;
  logic [WID_W-1:0]        width_r, width_nxt;
  logic [PREC_W-1:0]       prec_r, prec_nxt;
  logic [PREC_W-1:0]       pz_r, pz_nxt;
  logic [1:0]              plen_r, plen_nxt;

  ita_pkg::ita_in_t        in_d;
  logic                    is_neg;
  logic [VALUE_W-1:0]      mag;
  logic [EXT_W-1:0]        ext;
  logic [WID_W-1:0]        sat_w;
  logic [PREC_W-1:0]       sat_p;
  logic [SLOTS-1:0][3:0]   adj;
  logic [WID_W-1:0]        prec_x;
  logic [WID_W-1:0]        nd_x;
  logic [WID_W-1:0]        body;
  logic [WID_W-1:0]        pad;

  always_comb begin
    in_d   = in_item.data;
    is_neg = (in_d.req_type == ita_pkg::REQ_SDEC) && in_d.value[VALUE_W-1];
    mag    = is_neg ? ({VALUE_W{1'b0}} - in_d.value) : in_d.value;
    ext    = {{(EXT_W - VALUE_W){1'b0}}, in_d.value};
    sat_w  = (in_d.min_chars > WID_W'(ita_pkg::MAX_WIDTH)) ?
             WID_W'(ita_pkg::MAX_WIDTH) : in_d.min_chars;
    sat_p  = (in_d.min_digits > PREC_W'(ita_pkg::MAX_PRECISION)) ?
             PREC_W'(ita_pkg::MAX_PRECISION) : in_d.min_digits;
    for (int i = 0; i < SLOTS; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? (dig_r[i] + 4'd3) : dig_r[i];
    end
    prec_x = WID_W'(prec_r);
    nd_x   = WID_W'(nd_r);
    body   = WID_W'(neg_r) + WID_W'(plen_r) + WID_W'(pz_r) + nd_x;
    pad    = (width_r > body) ? (width_r - body) : '0;

    state_nxt = state_r;
    radix_nxt = radix_r;
    bin_nxt   = bin_r;
    dig_nxt   = dig_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    nd_nxt    = nd_r;
    neg_nxt   = neg_r;
    nz_nxt    = nz_r;
    ptr_nxt   = ptr_r;
    upper_nxt = upper_r;
    alt_nxt   = alt_r;
    left_nxt  = left_r;
    zfill_nxt = zfill_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    pz_nxt    = pz_r;
    plen_nxt  = plen_r;

    in_item.ready        = (state_r == ita_pkg::F_IDLE);
    rec_out.valid        = (state_r == ita_pkg::F_PUSH);
    rec_out.data.digits  = dig_r;
    rec_out.data.nd      = nd_r;
    rec_out.data.neg     = neg_r;
    rec_out.data.plen    = plen_r;
    rec_out.data.upper   = upper_r;
    rec_out.data.pz      = pz_r;
    rec_out.data.pad     = pad;
    rec_out.data.left    = left_r;
    rec_out.data.zfill   = zfill_r;

    case (state_r)
      ita_pkg::F_IDLE: begin
        if (in_item.valid) begin
          if (in_d.req_type inside {ita_pkg::REQ_LHEX, ita_pkg::REQ_UHEX, ita_pkg::REQ_PTR}) begin
            radix_nxt = ita_pkg::RDX_HEX;
            idx_nxt   = IDX_W'(ita_pkg::HEX_DIGITS - 1);
          end else if (in_d.req_type == ita_pkg::REQ_OCT) begin
            radix_nxt = ita_pkg::RDX_OCT;
            idx_nxt   = IDX_W'(ita_pkg::OCT_DIGITS - 1);
          end else begin
            radix_nxt = ita_pkg::RDX_DEC;
            idx_nxt   = IDX_W'(ita_pkg::DEC_DIGITS - 1);
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (radix_nxt == ita_pkg::RDX_HEX) begin
              dig_nxt[i] = ext[4*i +: 4];
            end else if (radix_nxt == ita_pkg::RDX_OCT) begin
              dig_nxt[i] = {1'b0, ext[3*i +: 3]};
            end else begin
              dig_nxt[i] = 4'd0;
            end
          end
          bin_nxt   = mag;
          step_nxt  = '1;
          neg_nxt   = is_neg;
          nz_nxt    = |in_d.value;
          ptr_nxt   = (in_d.req_type == ita_pkg::REQ_PTR);
          upper_nxt = (in_d.req_type == ita_pkg::REQ_UHEX);
          alt_nxt   = in_d.alt_prefix;
          left_nxt  = in_d.left_justify;
          zfill_nxt = !in_d.left_justify && in_d.zero_pad && (sat_p == '0);
          width_nxt = sat_w;
          prec_nxt  = sat_p;
          state_nxt = (radix_nxt == ita_pkg::RDX_DEC) ? ita_pkg::F_DABBLE : ita_pkg::F_SCAN;
        end
      end
      ita_pkg::F_DABBLE: begin
        dig_nxt[0] = {adj[0][2:0], bin_r[VALUE_W-1]};
        for (int i = 1; i < SLOTS; i++) begin
          dig_nxt[i] = {adj[i][2:0], adj[i-1][3]};
        end
        bin_nxt  = bin_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ita_pkg::F_SCAN;
        end
      end
      ita_pkg::F_SCAN: begin
        if ((dig_r[idx_r] != 4'd0) || (idx_r == '0)) begin
          nd_nxt    = ND_W'(idx_r) + ND_W'(1);
          state_nxt = ita_pkg::F_PLAN;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      ita_pkg::F_PLAN: begin
        pz_nxt = (prec_x > nd_x) ? PREC_W'(prec_x - nd_x) : '0;
        if (ptr_r) begin
          plen_nxt = 2'd2;
        end else if (alt_r && nz_r && (radix_r == ita_pkg::RDX_HEX)) begin
          plen_nxt = 2'd2;
        end else if (alt_r && nz_r && (radix_r == ita_pkg::RDX_OCT) && (prec_x <= nd_x)) begin
          plen_nxt = 2'd1;
        end else begin
          plen_nxt = 2'd0;
        end
        state_nxt = ita_pkg::F_PUSH;
      end
      ita_pkg::F_PUSH: begin
        if (rec_out.ready) begin
          state_nxt = ita_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = ita_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ita_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r <= radix_nxt;
    bin_r   <= bin_nxt;
    dig_r   <= dig_nxt;
    step_r  <= step_nxt;
    idx_r   <= idx_nxt;
    nd_r    <= nd_nxt;
    neg_r   <= neg_nxt;
    nz_r    <= nz_nxt;
    ptr_r   <= ptr_nxt;
    upper_r <= upper_nxt;
    alt_r   <= alt_nxt;
    left_r  <= left_nxt;
    zfill_r <= zfill_nxt;
    width_r <= width_nxt;
    prec_r  <= prec_nxt;
    pz_r    <= pz_nxt;
    plen_r  <= plen_nxt;
  end

endmodule

// ===== rtl/ita_queue.sv =====
// Short record queue between the front end and the character emitter.
// Depends on ita_pkg and ita_stream_if.
module ita_queue (
  input  logic          clk,
  input  logic          rst_n,
  ita_stream_if.sink    push_if,
  ita_stream_if.source  pop_if
);

  localparam int DEPTH = ita_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ita_pkg::ita_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  always_comb begin
    push_if.ready = (cnt_r != CNT_W'(DEPTH));
    pop_if.valid  = (cnt_r != '0);
    pop_if.data   = mem_r[rd_ptr_r];
    push          = push_if.valid && push_if.ready;
    pop           = pop_if.valid && pop_if.ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_r + PTR_W'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_r + PTR_W'(1));
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_if.data;
    end
  end

endmodule

// ===== rtl/ita_emit.sv =====
// Back end: walks the planned segments of one record and sends one character per beat.
// Depends on ita_pkg and ita_stream_if.
module ita_emit (
  input  logic          clk,
  input  logic          rst_n,
  ita_stream_if.sink    rec_in,
  ita_stream_if.source  out_item
);

  localparam int WID_W  = ita_pkg::WID_W;
  localparam int IDX_W  = ita_pkg::IDX_W;
  localparam int NSEG   = ita_pkg::SEG_COUNT;
  localparam int SEG_W  = $bits(ita_pkg::seg_t);
  localparam int SIDX_W = $clog2(NSEG);

  ita_pkg::seg_t     seg_r, seg_nxt;
  logic [WID_W-1:0]  cnt_r, cnt_nxt;
  ita_pkg::ita_rec_t rec_r, rec_nxt;
  logic [WID_W-1:0]  len_r [NSEG];
  logic [WID_W-1:0]  len_nxt [NSEG];
  logic              ov_r, ov_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic              last_r, last_nxt;

  ita_pkg::ita_rec_t rd;
  logic [WID_W-1:0]  lin [NSEG];
  ita_pkg::seg_t     first_seg;
  logic [WID_W-1:0]  first_len;
  ita_pkg::seg_t     nx_seg;
  logic [WID_W-1:0]  nx_len;
  logic              nx_found;
  logic              produce;
  logic [IDX_W-1:0]  dig_idx;
  logic [7:0]        ch;

  always_comb begin
    rd = rec_in.data;
    lin[SIDX_W'(ita_pkg::SEG_LPAD)] = (!rd.left && !rd.zfill) ? rd.pad : '0;
    lin[SIDX_W'(ita_pkg::SEG_SIGN)] = WID_W'(rd.neg);
    lin[SIDX_W'(ita_pkg::SEG_PFX0)] = WID_W'(rd.plen != 2'd0);
    lin[SIDX_W'(ita_pkg::SEG_PFXX)] = WID_W'(rd.plen == 2'd2);
    lin[SIDX_W'(ita_pkg::SEG_ZPAD)] = rd.zfill ? rd.pad : '0;
    lin[SIDX_W'(ita_pkg::SEG_PREC)] = WID_W'(rd.pz);
    lin[SIDX_W'(ita_pkg::SEG_DIG)]  = WID_W'(rd.nd);
    lin[SIDX_W'(ita_pkg::SEG_TPAD)] = rd.left ? rd.pad : '0;

    first_seg = ita_pkg::SEG_DIG;
    first_len = lin[SIDX_W'(ita_pkg::SEG_DIG)];
    for (int k = NSEG - 1; k >= 0; k--) begin
      if (lin[k] != '0) begin
        first_seg = ita_pkg::seg_t'(SEG_W'(k));
        first_len = lin[k];
      end
    end

    nx_seg   = ita_pkg::SEG_IDLE;
    nx_len   = '0;
    nx_found = 1'b0;
    for (int k = NSEG - 1; k >= 0; k--) begin
      if ((k > int'(seg_r)) && (len_r[k] != '0)) begin
        nx_seg   = ita_pkg::seg_t'(SEG_W'(k));
        nx_len   = len_r[k];
        nx_found = 1'b1;
      end
    end

    dig_idx = IDX_W'(cnt_r - WID_W'(1));
    case (seg_r)
      ita_pkg::SEG_LPAD, ita_pkg::SEG_TPAD: ch = ita_pkg::CH_SPACE;
      ita_pkg::SEG_SIGN:                    ch = ita_pkg::CH_MINUS;
      ita_pkg::SEG_PFX0, ita_pkg::SEG_ZPAD,
      ita_pkg::SEG_PREC:                    ch = ita_pkg::CH_ZERO;
      ita_pkg::SEG_PFXX: ch = rec_r.upper ? ita_pkg::CH_UX : ita_pkg::CH_LX;
      ita_pkg::SEG_DIG:  ch = ita_pkg::glyph(rec_r.digits[dig_idx], rec_r.upper);
      default:           ch = ita_pkg::CH_SPACE;
    endcase

    produce      = (seg_r != ita_pkg::SEG_IDLE) && (!ov_r || out_item.ready);
    rec_in.ready = (seg_r == ita_pkg::SEG_IDLE);

    out_item.valid          = ov_r;
    out_item.data.out_char  = ch_r;
    out_item.data.last_char = last_r;

    seg_nxt  = seg_r;
    cnt_nxt  = cnt_r;
    rec_nxt  = rec_r;
    len_nxt  = len_r;
    ch_nxt   = ch_r;
    last_nxt = last_r;
    ov_nxt   = ov_r && !out_item.ready;

    case (seg_r)
      ita_pkg::SEG_IDLE: begin
        if (rec_in.valid) begin
          rec_nxt = rd;
          len_nxt = lin;
          seg_nxt = first_seg;
          cnt_nxt = first_len;
        end
      end
      default: begin
        if (produce) begin
          ov_nxt   = 1'b1;
          ch_nxt   = ch;
          last_nxt = (cnt_r == WID_W'(1)) && !nx_found;
          if (cnt_r > WID_W'(1)) begin
            cnt_nxt = cnt_r - WID_W'(1);
          end else begin
            seg_nxt = nx_seg;
            cnt_nxt = nx_len;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= ita_pkg::SEG_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    len_r  <= len_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: front end, record queue, character emitter.
// Depends on ita_pkg, ita_stream_if, ita_front, ita_queue and ita_emit.
//
//   Channel   Dir  Payload                                             Handshake
//   in_item   in   value, req_type, min_chars, min_digits,             valid/ready
//                  alt_prefix, left_justify, zero_pad
//   out_item  out  out_char, last_char (one character per beat)        valid/ready
//
// Front end: accepts an item, runs double dabble for decimal values, scans for the leading digit,
// then plans the layout and hands over a record.
// Emitter: takes a record, then one character per cycle unless stalled, 1 to 64 per item.
// A two-record queue lets the front end convert the next item while the emitter drains.
// Reset (rst_n low, synchronous) idles both ends and empties the queue.
// A stalled output holds its beat; the emitter and then the queue and front end back up.
module integer_to_ascii_formatter (
  input  logic          clk,
  input  logic          rst_n,
  ita_stream_if.sink    in_item,
  ita_stream_if.source  out_item
);

  localparam int ND_W    = ita_pkg::ND_W;
  localparam int ND_LIMIT = ita_pkg::OCT_DIGITS;

  ita_stream_if #(.payload_t(ita_pkg::ita_rec_t)) rec_f ();
  ita_stream_if #(.payload_t(ita_pkg::ita_rec_t)) rec_b ();

  ita_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .rec_out (rec_f)
  );

  ita_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_if (rec_f),
    .pop_if  (rec_b)
  );

  ita_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_in   (rec_b),
    .out_item (out_item)
  );

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    rec_f.valid |-> (rec_f.data.nd != '0) && (rec_f.data.nd <= ND_W'(ND_LIMIT)))
    else $error("digit count out of range");

  a_zfill_right: assert property (@(posedge clk) disable iff (!rst_n)
    rec_f.valid |-> !(rec_f.data.zfill && rec_f.data.left))
    else $error("zero fill planned on a left-justified item");

  a_octal_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_f.valid && (rec_f.data.pz != '0)) |-> (rec_f.data.plen != 2'd1))
    else $error("octal prefix planned alongside precision zeros");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("front end ready again right after accepting an item");

endmodule

// ===== bench/integer_to_ascii_formatter_tb.sv =====
// Self-checking bench for integer_to_ascii_formatter: drives format requests on in_item,
// predicts every character in order and checks each out_item beat against it.
// Depends on ita_pkg, ita_stream_if and the formatter RTL.
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  ita_stream_if #(.payload_t(ita_pkg::ita_in_t))  in_bus ();
  ita_stream_if #(.payload_t(ita_pkg::ita_out_t)) out_bus ();

  integer_to_ascii_formatter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  ita_pkg::ita_out_t pending_chars[$];
  int       errors = 0;
  bit       pace_random = 1'b1;
  bit       hold_out_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] digit_char(input int unsigned d, input logic upper);
    if (d < 10) begin
      return ita_pkg::CH_ZERO + 8'(d);
    end
    return 8'(d - 10) + (upper ? "A" : "a");
  endfunction

  function automatic void format_item(input ita_pkg::ita_in_t it);
    logic [63:0] mag;
    logic [2:0]  kind;
    logic        upper;
    logic        neg;
    logic        nonzero;
    logic        zfill;
    logic [7:0]  mark;
    logic [7:0]  digs[ita_pkg::DIGIT_SLOTS];
    logic [7:0]  text[$];
    ita_pkg::ita_out_t beat;
    int unsigned width;
    int unsigned prec;
    int unsigned radix;
    int unsigned nd;
    int unsigned pz;
    int unsigned plen;
    int unsigned body;
    int unsigned pad;
    int unsigned d;
    int          n;
    width = (it.min_chars > ita_pkg::MAX_WIDTH) ? ita_pkg::MAX_WIDTH : it.min_chars;
    prec  = (it.min_digits > ita_pkg::MAX_PRECISION) ? ita_pkg::MAX_PRECISION : it.min_digits;
    kind  = it.req_type;
    if (kind == ita_pkg::REQ_LHEX || kind == ita_pkg::REQ_UHEX || kind == ita_pkg::REQ_PTR) begin
      radix = 16;
    end else if (kind == ita_pkg::REQ_OCT) begin
      radix = 8;
    end else begin
      radix = 10;
    end
    upper = (kind == ita_pkg::REQ_UHEX);
    mag = it.value;
    neg = (kind == ita_pkg::REQ_SDEC) && mag[63];
    if (neg) begin
      mag = -mag;
    end
    nonzero = (mag != 0);
    plen = 0;
    mark = ita_pkg::CH_LX;
    if (kind == ita_pkg::REQ_PTR) begin
      plen = 2;
    end else if (it.alt_prefix && nonzero &&
                 (kind == ita_pkg::REQ_LHEX || kind == ita_pkg::REQ_UHEX)) begin
      plen = 2;
      if (upper) begin
        mark = ita_pkg::CH_UX;
      end
    end
    nd = 0;
    do begin
      d = int'(mag % radix);
      mag = mag / radix;
      if (nd < ita_pkg::DIGIT_SLOTS) begin
        digs[nd] = digit_char(d, upper);
        nd++;
      end
    end while (mag != 0);
    pz = (prec > nd) ? prec - nd : 0;
    if (kind == ita_pkg::REQ_OCT && it.alt_prefix && nonzero && pz == 0) begin
      plen = 1;
    end
    body  = (neg ? 1 : 0) + plen + pz + nd;
    pad   = (width > body) ? width - body : 0;
    zfill = !it.left_justify && it.zero_pad && prec == 0;
    if (!it.left_justify && !zfill) begin
      repeat (pad) text.push_back(ita_pkg::CH_SPACE);
    end
    if (neg) begin
      text.push_back(ita_pkg::CH_MINUS);
    end
    if (plen >= 1) begin
      text.push_back(ita_pkg::CH_ZERO);
    end
    if (plen == 2) begin
      text.push_back(mark);
    end
    if (zfill) begin
      repeat (pad) text.push_back(ita_pkg::CH_ZERO);
    end
    repeat (pz) text.push_back(ita_pkg::CH_ZERO);
    for (int k = int'(nd) - 1; k >= 0; k--) begin
      text.push_back(digs[k]);
    end
    if (it.left_justify) begin
      repeat (pad) text.push_back(ita_pkg::CH_SPACE);
    end
    n = (text.size() > ita_pkg::MAX_WIDTH) ? ita_pkg::MAX_WIDTH : text.size();
    for (int i = 0; i < n; i++) begin
      beat.out_char  = text[i];
      beat.last_char = (i == n - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  function automatic ita_pkg::ita_in_t make_item(input logic [63:0] value,
                                                 input logic [2:0] kind,
                                                 input int width, input int prec,
                                                 input bit alt, input bit left, input bit zpad);
    ita_pkg::ita_in_t it;
    it.value        = value;
    it.req_type     = kind;
    it.min_chars    = ita_pkg::WID_W'(width);
    it.min_digits   = ita_pkg::PREC_W'(prec);
    it.alt_prefix   = alt;
    it.left_justify = left;
    it.zero_pad     = zpad;
    return it;
  endfunction

  function automatic ita_pkg::ita_in_t random_item();
    logic [63:0] value;
    int          width;
    int          prec;
    case ($urandom_range(0, 5))
      0: value = {$urandom, $urandom};
      1: value = 64'($urandom_range(0, 20));
      2: value = 64'd1 << $urandom_range(0, 63);
      3: value = ~64'd0 - 64'($urandom_range(0, 20));
      4: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
    endcase
    width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 24);
    case ($urandom_range(0, 3))
      0: prec = 0;
      1: prec = $urandom_range(0, 8);
      2: prec = $urandom_range(0, 34);
      default: prec = $urandom_range(0, 63);
    endcase
    return make_item(value, 3'($urandom_range(0, 7)), width, prec,
                     $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  task automatic send_item(input ita_pkg::ita_in_t it);
    int gap;
    gap = pace_random ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    do @(posedge clk); while (!in_bus.ready);
    format_item(it);
  endtask

  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out_req) begin
        out_bus.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out_req = 1'b0;
      end
      gap = pace_random ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  always @(posedge clk) begin
    ita_pkg::ita_out_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, out_bus.data.out_char, out_bus.data.last_char);
      end else begin
        want = pending_chars.pop_front();
        if (out_bus.data.out_char !== want.out_char) begin
          errors++;
          $display("%0t: out_char mismatch, expected %h, actual %h",
                   $time, want.out_char, out_bus.data.out_char);
        end
        if (out_bus.data.last_char !== want.last_char) begin
          errors++;
          $display("%0t: last_char mismatch, expected %b, actual %b",
                   $time, want.last_char, out_bus.data.last_char);
        end
      end
    end
  end

  task automatic test_directed_edges();
    send_item(make_item(64'd0, ita_pkg::REQ_SDEC, 0, 5, 0, 0, 0));
    send_item(make_item(64'd0, ita_pkg::REQ_LHEX, 6, 0, 1, 0, 1));
    send_item(make_item(64'd0, ita_pkg::REQ_PTR, 0, 0, 0, 0, 0));
    send_item(make_item(64'd0, ita_pkg::REQ_OCT, 4, 0, 1, 1, 0));
    send_item(make_item(64'h8000_0000_0000_0000, ita_pkg::REQ_SDEC, 0, 0, 0, 0, 0));
    send_item(make_item(~64'd0, ita_pkg::REQ_SDEC, 8, 0, 0, 0, 1));
    send_item(make_item(~64'd0, ita_pkg::REQ_UDEC, 0, 0, 0, 0, 0));
    send_item(make_item(~64'd0, ita_pkg::REQ_UHEX, 0, 0, 1, 0, 0));
    send_item(make_item(64'hdead_beef_0123_4567, ita_pkg::REQ_LHEX, 20, 0, 1, 0, 1));
    send_item(make_item(~64'd0, ita_pkg::REQ_OCT, 0, 0, 1, 0, 0));
    send_item(make_item(64'o755, ita_pkg::REQ_OCT, 0, 5, 1, 0, 0));
    send_item(make_item(64'o755, ita_pkg::REQ_OCT, 0, 3, 1, 0, 0));
    send_item(make_item(64'd42, ita_pkg::REQ_UDEC, 10, 0, 0, 1, 1));
    send_item(make_item(64'd42, ita_pkg::REQ_UDEC, 10, 4, 0, 0, 1));
    send_item(make_item(-64'd42, ita_pkg::REQ_SDEC, 10, 0, 0, 0, 1));
    send_item(make_item(64'd1234, 3'd6, 6, 0, 1, 0, 0));
    send_item(make_item(64'd1234, 3'd7, 0, 2, 0, 1, 0));
    send_item(make_item(64'hff, ita_pkg::REQ_PTR, 127, 0, 1, 0, 1));
    send_item(make_item(64'd7, ita_pkg::REQ_SDEC, 0, 63, 0, 0, 0));
    send_item(make_item(64'habc, ita_pkg::REQ_UHEX, 64, 40, 1, 1, 1));
    send_item(make_item(64'd5, ita_pkg::REQ_LHEX, 64, 0, 0, 1, 0));
  endtask

  task automatic test_random_formats(input int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_back_to_back();
    pace_random = 1'b0;
    repeat (60) send_item(random_item());
    pace_random = 1'b1;
  endtask

  task automatic test_output_stall();
    pace_random = 1'b0;
    hold_out_req = 1'b1;
    repeat (25) send_item(make_item(64'($urandom_range(0, 255)), ita_pkg::REQ_LHEX,
                                    $urandom_range(0, 8), 0, 1, 0, 0));
    pace_random = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_formats(200);
    test_output_stall();
    test_back_to_back();
    test_random_formats(140);
    in_bus.valid <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (pending_chars.size() != 0) begin
      errors++;
      $display("%0t: beats missing, expected %0d more, actual 0",
               $time, pending_chars.size());
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ita_pkg.sv
rtl/ita_stream_if.sv
rtl/ita_front.sv
rtl/ita_queue.sv
rtl/ita_emit.sv
rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
